// ===== rtl/sn2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sn2d_pkg
// Shared types, constants and tables for the 2D simplex noise block.
// ----------------------------------------------------------------------------
package sn2d_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF   = 14;

    // working format fraction bits
    localparam int WF = 24;

    localparam int OFS_W   = 26;
    localparam int W_W     = 27;
    localparam int G_W     = 30;
    localparam int Q_DEPTH = 4;

    localparam logic [63:0] HASH_K = 64'd6026932503003350773;
    localparam logic [63:0] LAT_X  = 64'd5910200641878280303;
    localparam logic [63:0] LAT_Y  = 64'd6452764530575939509;

    localparam logic signed [32:0] SKEW_Q32 = 33'sd1572067139;
    localparam logic signed [23:0] UNSK_W   = -24'sd3545443;
    localparam logic signed [24:0] RSQ_W    = 25'sd11184811;
    localparam logic signed [26:0] A1T_W    = -27'sd52927092;

    typedef logic signed [2:0]       delta_t;
    typedef logic signed [OFS_W-1:0] ofs_t;
    typedef logic signed [W_W-1:0]   wgt_t;
    typedef logic signed [G_W-1:0]   grad_t;

    localparam ofs_t OFS_UNSK = -26'sd3545443;
    localparam ofs_t OFS_DIAG = 26'sd9686330;
    localparam ofs_t OFS_U3P2 = 26'sd22918103;
    localparam ofs_t OFS_U3P1 = 26'sd6140887;
    localparam ofs_t OFS_UP1  = 26'sd13231773;

    // one classified sample: lattice products and four vertex jobs
    typedef struct packed {
        logic [63:0]  lx;
        logic [63:0]  ly;
        delta_t [3:0] dx;
        delta_t [3:0] dy;
        ofs_t [3:0]   vx;
        ofs_t [3:0]   vy;
        wgt_t [3:0]   w;
    } vtx_job_t;

    localparam grad_t GA = 30'sd117120010;
    localparam grad_t GB = 30'sd282752717;
    localparam grad_t GC = 30'sd39947454;
    localparam grad_t GD = 30'sd186311031;
    localparam grad_t GE = 30'sd242805263;
    localparam grad_t GF = 30'sd303431041;

    localparam grad_t GTAB [48] = '{
        GA, GB,   GB, GA,   GB, -GA,  GA, -GB,
        -GA, -GB, -GB, -GA, -GB, GA,  -GA, GB,
        GC, GF,   GD, GE,   GE, GD,   GF, GC,
        GF, -GC,  GE, -GD,  GD, -GE,  GC, -GF,
        -GC, -GF, -GD, -GE, -GE, -GD, -GF, -GC,
        -GF, GC,  -GE, GD,  -GD, GE,  -GC, GF
    };

    // remainder by 24 of a 7-bit value
    function automatic logic [4:0] mod24(input logic [6:0] v);
        logic [6:0] a;
        logic [6:0] b;
        logic [6:0] c;
        a = (v >= 7'd96) ? v - 7'd96 : v;
        b = (a >= 7'd48) ? a - 7'd48 : a;
        c = (b >= 7'd24) ? b - 7'd24 : b;
        return c[4:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sn2d_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sn2d_front
// Skews and floors the sample, works out offsets, picks the two far
// vertices and their weights, and hands a vertex job to the queue.
// ----------------------------------------------------------------------------
module sn2d_front #(
    parameter int COORD_FRAC_BITS = sn2d_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    output logic                job_valid,
    output sn2d_pkg::vtx_job_t  job,
    input  logic                job_full
);
    import sn2d_pkg::*;

    localparam int CW = 34 - COORD_FRAC_BITS;
    localparam int CLS_A = 0;
    localparam int CLS_B = 1;
    localparam int CLS_C = 2;
    localparam int CLS_D = 3;

    logic [7:0] vld_reg;
    logic       advance;

    assign advance      = !(vld_reg[7] && job_full);
    assign sample_stall = !advance;
    assign job_valid    = vld_reg[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[6:0], sample_valid};
        end
    end

    // stage 1: capture
    logic signed [31:0] s1_x_reg, s1_y_reg;

    // stage 2: skew product
    logic signed [32:0] s2_sum;
    logic signed [65:0] s2_prod_next, s2_prod_reg;
    logic signed [31:0] s2_x_reg, s2_y_reg;

    assign s2_sum       = 33'(s1_x_reg) + 33'(s1_y_reg);
    assign s2_prod_next = s2_sum * SKEW_Q32;

    // stage 3: skewed coordinates
    logic signed [65:0] s3_rnd;
    logic signed [33:0] s3_sk;
    logic signed [33:0] s3_sx_next, s3_sy_next, s3_sx_reg, s3_sy_reg;

    assign s3_rnd     = s2_prod_reg + 66'sd2147483648;
    assign s3_sk      = $signed(s3_rnd[65:32]);
    assign s3_sx_next = 34'(s2_x_reg) + s3_sk;
    assign s3_sy_next = 34'(s2_y_reg) + s3_sk;

    // stage 4: cell, fraction, unskew product, region compares
    logic signed [CW-1:0] s4_cx_next, s4_cy_next, s4_cx_reg, s4_cy_reg;
    logic [WF-1:0]        s4_fx_next, s4_fy_next, s4_fx_reg, s4_fy_reg;
    logic [WF:0]          s4_fsum;
    logic signed [49:0]   s4_pt_next, s4_pt_reg;
    logic signed [26:0]   s4_ax, s4_ay;
    logic [3:0]           s4_cls_next, s4_cls_reg;

    assign s4_cx_next = $signed(s3_sx_reg[33:COORD_FRAC_BITS]);
    assign s4_cy_next = $signed(s3_sy_reg[33:COORD_FRAC_BITS]);
    assign s4_fx_next = WF'(s3_sx_reg[COORD_FRAC_BITS-1:0]) << (WF - COORD_FRAC_BITS);
    assign s4_fy_next = WF'(s3_sy_reg[COORD_FRAC_BITS-1:0]) << (WF - COORD_FRAC_BITS);
    assign s4_fsum    = {1'b0, s4_fx_next} + {1'b0, s4_fy_next};
    assign s4_pt_next = $signed({1'b0, s4_fsum}) * UNSK_W;
    assign s4_ax      = ($signed({3'b000, s4_fx_next}) <<< 1) - $signed({3'b000, s4_fy_next});
    assign s4_ay      = ($signed({3'b000, s4_fy_next}) <<< 1) - $signed({3'b000, s4_fx_next});

    always_comb
    begin
        s4_cls_next        = '0;
        s4_cls_next[CLS_A] = s4_ax > 27'sd16777216;
        s4_cls_next[CLS_B] = s4_ay > 27'sd16777216;
        s4_cls_next[CLS_C] = s4_ax < 27'sd0;
        s4_cls_next[CLS_D] = {s4_fy_next, 1'b0} < {1'b0, s4_fx_next};
    end

    // stage 5: unskewed offsets and lattice partial products
    logic signed [49:0]    s5_rnd;
    ofs_t                  s5_tt_next, s5_tt_reg;
    ofs_t                  s5_ox_next, s5_oy_next, s5_ox_reg, s5_oy_reg;
    logic                  s5_upper_reg;
    logic [3:0]            s5_cls_reg;
    logic signed [CW+32:0] s5_plx_next, s5_ply_next, s5_plx_reg, s5_ply_reg;
    logic signed [CW+32:0] s5_phx_full, s5_phy_full;
    logic [31:0]           s5_phx_reg, s5_phy_reg;

    assign s5_rnd      = s4_pt_reg + 50'sd8388608;
    assign s5_tt_next  = $signed(s5_rnd[49:24]);
    assign s5_ox_next  = $signed({2'b00, s4_fx_reg}) + s5_tt_next;
    assign s5_oy_next  = $signed({2'b00, s4_fy_reg}) + s5_tt_next;
    assign s5_plx_next = s4_cx_reg * $signed({1'b0, LAT_X[31:0]});
    assign s5_ply_next = s4_cy_reg * $signed({1'b0, LAT_Y[31:0]});
    assign s5_phx_full = s4_cx_reg * $signed({1'b0, LAT_X[63:32]});
    assign s5_phy_full = s4_cy_reg * $signed({1'b0, LAT_Y[63:32]});

    // stage 6: lattice products and vertex selection
    logic [63:0] s6_lx_next, s6_ly_next, s6_lx_reg, s6_ly_reg;
    delta_t      s6_dx_next [4];
    delta_t      s6_dy_next [4];
    ofs_t        s6_offx [4];
    ofs_t        s6_offy [4];
    delta_t      s6_dx_reg [4];
    delta_t      s6_dy_reg [4];
    ofs_t        s6_vx_reg [4];
    ofs_t        s6_vy_reg [4];
    ofs_t        s6_tt_reg;

    assign s6_lx_next = 64'(s5_plx_reg) + {s5_phx_reg, 32'b0};
    assign s6_ly_next = 64'(s5_ply_reg) + {s5_phy_reg, 32'b0};

    always_comb
    begin
        s6_dx_next[0] = 3'sd0;
        s6_dy_next[0] = 3'sd0;
        s6_offx[0]    = '0;
        s6_offy[0]    = '0;
        s6_dx_next[1] = 3'sd1;
        s6_dy_next[1] = 3'sd1;
        s6_offx[1]    = OFS_DIAG;
        s6_offy[1]    = OFS_DIAG;
        if (s5_upper_reg)
        begin
            if (s5_cls_reg[CLS_A])
            begin
                s6_dx_next[2] = 3'sd2;
                s6_dy_next[2] = 3'sd1;
                s6_offx[2]    = OFS_U3P2;
                s6_offy[2]    = OFS_U3P1;
            end
            else
            begin
                s6_dx_next[2] = 3'sd0;
                s6_dy_next[2] = 3'sd1;
                s6_offx[2]    = OFS_UNSK;
                s6_offy[2]    = OFS_UP1;
            end
            if (s5_cls_reg[CLS_B])
            begin
                s6_dx_next[3] = 3'sd1;
                s6_dy_next[3] = 3'sd2;
                s6_offx[3]    = OFS_U3P1;
                s6_offy[3]    = OFS_U3P2;
            end
            else
            begin
                s6_dx_next[3] = 3'sd1;
                s6_dy_next[3] = 3'sd0;
                s6_offx[3]    = OFS_UP1;
                s6_offy[3]    = OFS_UNSK;
            end
        end
        else
        begin
            if (s5_cls_reg[CLS_C])
            begin
                s6_dx_next[2] = -3'sd1;
                s6_dy_next[2] = 3'sd0;
                s6_offx[2]    = -OFS_UP1;
                s6_offy[2]    = -OFS_UNSK;
            end
            else
            begin
                s6_dx_next[2] = 3'sd1;
                s6_dy_next[2] = 3'sd0;
                s6_offx[2]    = OFS_UP1;
                s6_offy[2]    = OFS_UNSK;
            end
            if (s5_cls_reg[CLS_D])
            begin
                s6_dx_next[3] = 3'sd0;
                s6_dy_next[3] = -3'sd1;
                s6_offx[3]    = -OFS_UNSK;
                s6_offy[3]    = -OFS_UP1;
            end
            else
            begin
                s6_dx_next[3] = 3'sd0;
                s6_dy_next[3] = 3'sd1;
                s6_offx[3]    = OFS_UNSK;
                s6_offy[3]    = OFS_UP1;
            end
        end
    end

    // stage 7: squares
    logic [63:0]        s7_lx_reg, s7_ly_reg;
    delta_t             s7_dx_reg [4];
    delta_t             s7_dy_reg [4];
    ofs_t               s7_vx_reg [4];
    ofs_t               s7_vy_reg [4];
    logic signed [51:0] s7_sq0x_reg, s7_sq0y_reg, s7_sq2x_reg, s7_sq2y_reg;
    logic signed [51:0] s7_sq3x_reg, s7_sq3y_reg;
    logic signed [52:0] s7_pa_reg;

    // stage 8: weights
    logic signed [27:0] s8_r0x, s8_r0y, s8_r2x, s8_r2y, s8_r3x, s8_r3y;
    logic signed [52:0] s8_pa_rnd;
    logic signed [28:0] s8_rpa;
    logic signed [28:0] s8_w0, s8_w1, s8_w2, s8_w3;
    vtx_job_t           job_next, job_reg;

    function automatic logic signed [27:0] rnd_sq(input logic signed [51:0] v);
        logic signed [51:0] t;
        t = v + 52'sd8388608;
        return $signed(t[51:24]);
    endfunction

    assign s8_r0x    = rnd_sq(s7_sq0x_reg);
    assign s8_r0y    = rnd_sq(s7_sq0y_reg);
    assign s8_r2x    = rnd_sq(s7_sq2x_reg);
    assign s8_r2y    = rnd_sq(s7_sq2y_reg);
    assign s8_r3x    = rnd_sq(s7_sq3x_reg);
    assign s8_r3y    = rnd_sq(s7_sq3y_reg);
    assign s8_pa_rnd = s7_pa_reg + 53'sd8388608;
    assign s8_rpa    = $signed(s8_pa_rnd[52:24]);
    assign s8_w0     = 29'(RSQ_W) - 29'(s8_r0x) - 29'(s8_r0y);
    assign s8_w1     = s8_rpa - 29'(RSQ_W) + s8_w0;
    assign s8_w2     = 29'(RSQ_W) - 29'(s8_r2x) - 29'(s8_r2y);
    assign s8_w3     = 29'(RSQ_W) - 29'(s8_r3x) - 29'(s8_r3y);

    always_comb
    begin
        job_next.lx = s7_lx_reg;
        job_next.ly = s7_ly_reg;
        for (int i = 0; i < 4; i++)
        begin
            job_next.dx[i] = s7_dx_reg[i];
            job_next.dy[i] = s7_dy_reg[i];
            job_next.vx[i] = s7_vx_reg[i];
            job_next.vy[i] = s7_vy_reg[i];
        end
        job_next.w[0] = W_W'(s8_w0);
        job_next.w[1] = W_W'(s8_w1);
        // far vertices drop out when the weight is not positive
        job_next.w[2] = (s8_w2 > 29'sd0) ? W_W'(s8_w2) : '0;
        job_next.w[3] = (s8_w3 > 29'sd0) ? W_W'(s8_w3) : '0;
    end

    assign job = job_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg     <= x_coord;
            s1_y_reg     <= y_coord;
            s2_prod_reg  <= s2_prod_next;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s3_sx_reg    <= s3_sx_next;
            s3_sy_reg    <= s3_sy_next;
            s4_cx_reg    <= s4_cx_next;
            s4_cy_reg    <= s4_cy_next;
            s4_fx_reg    <= s4_fx_next;
            s4_fy_reg    <= s4_fy_next;
            s4_pt_reg    <= s4_pt_next;
            s4_cls_reg   <= s4_cls_next;
            s5_tt_reg    <= s5_tt_next;
            s5_ox_reg    <= s5_ox_next;
            s5_oy_reg    <= s5_oy_next;
            s5_upper_reg <= s5_tt_next < UNSK_W;
            s5_cls_reg   <= s4_cls_reg;
            s5_plx_reg   <= s5_plx_next;
            s5_ply_reg   <= s5_ply_next;
            s5_phx_reg   <= s5_phx_full[31:0];
            s5_phy_reg   <= s5_phy_full[31:0];
            s6_lx_reg    <= s6_lx_next;
            s6_ly_reg    <= s6_ly_next;
            s6_tt_reg    <= s5_tt_reg;
            for (int i = 0; i < 4; i++)
            begin
                s6_dx_reg[i] <= s6_dx_next[i];
                s6_dy_reg[i] <= s6_dy_next[i];
                s6_vx_reg[i] <= s5_ox_reg - s6_offx[i];
                s6_vy_reg[i] <= s5_oy_reg - s6_offy[i];
                s7_dx_reg[i] <= s6_dx_reg[i];
                s7_dy_reg[i] <= s6_dy_reg[i];
                s7_vx_reg[i] <= s6_vx_reg[i];
                s7_vy_reg[i] <= s6_vy_reg[i];
            end
            s7_lx_reg   <= s6_lx_reg;
            s7_ly_reg   <= s6_ly_reg;
            s7_sq0x_reg <= s6_vx_reg[0] * s6_vx_reg[0];
            s7_sq0y_reg <= s6_vy_reg[0] * s6_vy_reg[0];
            s7_sq2x_reg <= s6_vx_reg[2] * s6_vx_reg[2];
            s7_sq2y_reg <= s6_vy_reg[2] * s6_vy_reg[2];
            s7_sq3x_reg <= s6_vx_reg[3] * s6_vx_reg[3];
            s7_sq3y_reg <= s6_vy_reg[3] * s6_vy_reg[3];
            s7_pa_reg   <= A1T_W * s6_tt_reg;
            job_reg     <= job_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sn2d_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sn2d_queue
// Short queue of vertex jobs between the front and back pipelines.
// ----------------------------------------------------------------------------
module sn2d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sn2d_pkg::vtx_job_t wr_data,
    output logic               full,
    output logic               rd_valid,
    output sn2d_pkg::vtx_job_t rd_data,
    input  logic               pop
);
    import sn2d_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    vtx_job_t      entry_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = count_reg == (PW+1)'(Q_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sn2d_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sn2d_back
// Hashes the four vertices, looks up gradients, forms the weighted
// contributions, sums them and rounds to the output format.
// ----------------------------------------------------------------------------
module sn2d_back #(
    parameter int OUT_FRAC_BITS = sn2d_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [63:0]        noise_seed,
    input  logic               job_valid,
    input  sn2d_pkg::vtx_job_t job,
    output logic               job_pop,
    output logic               noise_valid,
    input  logic               noise_stall,
    output logic signed [15:0] noise_value
);
    import sn2d_pkg::*;

    localparam int SH = 2 * WF - OUT_FRAC_BITS;

    logic [10:0] vld_reg;
    logic        advance;

    assign advance     = !(vld_reg[10] && noise_stall);
    assign job_pop     = advance && job_valid;
    assign noise_valid = vld_reg[10];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[9:0], job_valid};
        end
    end

    function automatic logic [63:0] lat_step(input delta_t d, input logic [63:0] k);
        logic [63:0] r;
        priority if (d == -3'sd1)
        begin
            r = -k;
        end
        else if (d == 3'sd1)
        begin
            r = k;
        end
        else if (d == 3'sd2)
        begin
            r = k << 1;
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    vtx_job_t           b1_job_reg;

    logic [63:0]        b2_key_next [4];
    logic [63:0]        b2_key_reg [4];
    logic signed [53:0] b2_wsq_reg [4];
    ofs_t               b2_vx_reg [4];
    ofs_t               b2_vy_reg [4];

    logic [63:0]        b3_pll_reg [4];
    logic [31:0]        b3_plh_reg [4];
    logic [31:0]        b3_phl_reg [4];
    logic signed [53:0] b3_wrnd [4];
    logic [27:0]        b3_w2_reg [4];
    ofs_t               b3_vx_reg [4];
    ofs_t               b3_vy_reg [4];

    logic [63:0]        b4_h [4];
    logic [63:0]        b4_hm [4];
    logic [4:0]         b4_idx_reg [4];
    logic [55:0]        b4_w4p_reg [4];
    ofs_t               b4_vx_reg [4];
    ofs_t               b4_vy_reg [4];

    logic [55:0]        b5_w4rnd [4];
    grad_t              b5_gx_reg [4];
    grad_t              b5_gy_reg [4];
    logic [29:0]        b5_w4_reg [4];
    ofs_t               b5_vx_reg [4];
    ofs_t               b5_vy_reg [4];

    logic signed [55:0] b6_mx_reg [4];
    logic signed [55:0] b6_my_reg [4];
    logic [29:0]        b6_w4_reg [4];

    logic signed [56:0] b7_sum [4];
    logic signed [32:0] b7_dot_reg [4];
    logic [29:0]        b7_w4_reg [4];

    logic signed [63:0] b8_c_reg [4];
    logic signed [63:0] b9_s01_reg, b9_s23_reg;
    logic signed [63:0] b10_acc_reg;

    logic signed [63:0] b11_rnd;
    logic signed [63:0] b11_res;
    logic signed [15:0] b11_sat;
    logic signed [15:0] noise_value_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            b2_key_next[i] = noise_seed
                           ^ (b1_job_reg.lx + lat_step(b1_job_reg.dx[i], LAT_X))
                           ^ (b1_job_reg.ly + lat_step(b1_job_reg.dy[i], LAT_Y));
            b3_wrnd[i]  = b2_wsq_reg[i] + 54'sd8388608;
            b4_h[i]     = b3_pll_reg[i] + {b3_plh_reg[i] + b3_phl_reg[i], 32'b0};
            b4_hm[i]    = b4_h[i] ^ (b4_h[i] >> 58);
            b5_w4rnd[i] = b4_w4p_reg[i] + 56'd8388608;
            b7_sum[i]   = 57'(b6_mx_reg[i]) + 57'(b6_my_reg[i]) + 57'sd8388608;
        end
    end

    assign b11_rnd = b10_acc_reg + (64'sd1 <<< (SH - 1));
    assign b11_res = b11_rnd >>> SH;

    always_comb
    begin
        priority if (b11_res > 64'sd32767)
        begin
            b11_sat = 16'sh7fff;
        end
        else if (b11_res < -64'sd32768)
        begin
            b11_sat = -16'sh8000;
        end
        else
        begin
            b11_sat = b11_res[15:0];
        end
    end

    assign noise_value = noise_value_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_job_reg <= job;
            for (int i = 0; i < 4; i++)
            begin
                b2_key_reg[i] <= b2_key_next[i];
                b2_wsq_reg[i] <= $signed(b1_job_reg.w[i]) * $signed(b1_job_reg.w[i]);
                b2_vx_reg[i]  <= $signed(b1_job_reg.vx[i]);
                b2_vy_reg[i]  <= $signed(b1_job_reg.vy[i]);

                b3_pll_reg[i] <= {32'b0, b2_key_reg[i][31:0]} * {32'b0, HASH_K[31:0]};
                b3_plh_reg[i] <= b2_key_reg[i][31:0] * HASH_K[63:32];
                b3_phl_reg[i] <= b2_key_reg[i][63:32] * HASH_K[31:0];
                b3_w2_reg[i]  <= b3_wrnd[i][51:24];
                b3_vx_reg[i]  <= b2_vx_reg[i];
                b3_vy_reg[i]  <= b2_vy_reg[i];

                b4_idx_reg[i] <= mod24(b4_hm[i][7:1]);
                b4_w4p_reg[i] <= {28'b0, b3_w2_reg[i]} * {28'b0, b3_w2_reg[i]};
                b4_vx_reg[i]  <= b3_vx_reg[i];
                b4_vy_reg[i]  <= b3_vy_reg[i];

                b5_gx_reg[i]  <= GTAB[{b4_idx_reg[i], 1'b0}];
                b5_gy_reg[i]  <= GTAB[{b4_idx_reg[i], 1'b1}];
                b5_w4_reg[i]  <= b5_w4rnd[i][53:24];
                b5_vx_reg[i]  <= b4_vx_reg[i];
                b5_vy_reg[i]  <= b4_vy_reg[i];

                b6_mx_reg[i]  <= b5_gx_reg[i] * b5_vx_reg[i];
                b6_my_reg[i]  <= b5_gy_reg[i] * b5_vy_reg[i];
                b6_w4_reg[i]  <= b5_w4_reg[i];

                b7_dot_reg[i] <= $signed(b7_sum[i][56:24]);
                b7_w4_reg[i]  <= b6_w4_reg[i];

                b8_c_reg[i]   <= $signed({1'b0, b7_w4_reg[i]}) * b7_dot_reg[i];
            end
            b9_s01_reg      <= b8_c_reg[0] + b8_c_reg[1];
            b9_s23_reg      <= b8_c_reg[2] + b8_c_reg[3];
            b10_acc_reg     <= b9_s01_reg + b9_s23_reg;
            noise_value_reg <= b11_sat;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/simplex_noise_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// simplex_noise_2d
// 2D simplex gradient noise, one sample per clock while sample_stall is low.
//
// sample channel: sample_valid / sample_stall carry x_coord and y_coord,
//   signed fixed point with COORD_FRAC_BITS fraction bits; one transaction
//   is one point
// noise channel: noise_valid / noise_stall carry noise_value, signed with
//   OUT_FRAC_BITS fraction bits, saturated; one result per sample, in order
// cfg_write_en / cfg_write_data load the 64-bit seed; write only when idle
// throughput: one sample per cycle while sample_stall is low
// pipeline: 8 front stages, one queue stage, 11 back stages
// reset: pipelines and queue empty, seed cleared to zero
// receiver stall: the back pipeline holds its output, the four-entry queue
//   fills, then the front holds and sample_stall rises
// ----------------------------------------------------------------------------
module simplex_noise_2d #(
    parameter int COORD_FRAC_BITS = sn2d_pkg::COORD_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = sn2d_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [63:0]        cfg_write_data,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic               noise_valid,
    input  logic               noise_stall,
    output logic signed [15:0] noise_value
);
    import sn2d_pkg::*;

    logic [63:0] seed_reg;
    logic        front_valid;
    vtx_job_t    front_job;
    logic        q_full;
    logic        q_valid;
    vtx_job_t    q_job;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            seed_reg <= cfg_write_data;
        end
    end

    sn2d_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .job_valid    (front_valid),
        .job          (front_job),
        .job_full     (q_full)
    );

    sn2d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .wr_data  (front_job),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_data  (q_job),
        .pop      (q_pop)
    );

    sn2d_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .noise_seed  (seed_reg),
        .job_valid   (q_valid),
        .job         (q_job),
        .job_pop     (q_pop),
        .noise_valid (noise_valid),
        .noise_stall (noise_stall),
        .noise_value (noise_value)
    );

endmodule
`default_nettype wire
